>>> sv/ais_position_report_decoder_top_macros.svh
// Assertion macros shared by the AIS position report decoder RTL.
`ifndef AIS_POSITION_REPORT_DECODER_TOP_MACROS_SVH
`define AIS_POSITION_REPORT_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while in reset
`define AISP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while in reset
`define AISP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define AISP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AISP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> sv/aisp_pkg.sv
// Shared types, constants and helper functions of the AIS position report decoder.
package aisp_pkg;

    // Character codes
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
    localparam logic [7:0] CHAR_A     = 8'h41;  // 'A'
    localparam logic [7:0] CHAR_I     = 8'h49;  // 'I'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_STAR  = 8'h2A;  // '*'

    // Six-bit armoring
    localparam int ARMOR_OFFSET = 48;
    localparam int ARMOR_LIMIT  = 40;
    localparam int ARMOR_GAP    = 8;

    // Line framing
    localparam int PREFIX_LEN    = 3;
    localparam int LINE_POS_W    = 2;
    localparam int FIELD_W       = 3;
    localparam int PAYLOAD_FIELD = 5;
    localparam int SYMBOL_BITS   = 6;
    localparam int MAX_SYMBOLS   = 28;
    localparam int SYM_CNT_W     = $clog2(MAX_SYMBOLS + 1);
    localparam int PAYLOAD_BITS  = SYMBOL_BITS * MAX_SYMBOLS;
    localparam int MSG_TYPE_POS  = 1;

    // Bit offsets within the payload string, MSB first
    localparam int POS_REPEAT   = 6;
    localparam int POS_MMSI     = 8;
    localparam int POS_STATUS   = 38;
    localparam int POS_TURN     = 42;
    localparam int POS_SPEED    = 50;
    localparam int POS_ACCURACY = 60;
    localparam int POS_LON      = 61;
    localparam int POS_LAT      = 89;
    localparam int POS_COURSE   = 116;
    localparam int POS_HEADING  = 128;
    localparam int POS_SECOND   = 137;
    localparam int POS_MANEUVER = 143;
    localparam int POS_RAIM     = 148;
    localparam int POS_RADIO    = 149;

    typedef logic [PAYLOAD_BITS-1:0] payload_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // Expected prefix character at a given line position
    function automatic logic [7:0] prefix_char(input logic [LINE_POS_W-1:0] pos);
        logic [7:0] ch;
        unique case (pos)
            2'd0:    ch = CHAR_BANG;
            2'd1:    ch = CHAR_A;
            2'd2:    ch = CHAR_I;
            default: ch = CHAR_BANG;
        endcase
        return ch;
    endfunction

    // ASCII character to six-bit symbol
    function automatic logic [SYMBOL_BITS-1:0] dearmor(input logic [7:0] c);
        logic [7:0] d;
        d = c - 8'(ARMOR_OFFSET);
        if (c > 8'(ARMOR_OFFSET + ARMOR_LIMIT))
            d = d - 8'(ARMOR_GAP);
        return d[SYMBOL_BITS-1:0];
    endfunction

endpackage

>>> sv/aisp_front.sv
// Line parser: prefix check, field counting and payload symbol capture.
`include "ais_position_report_decoder_top_macros.svh"

module aisp_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  logic [7:0]          char_byte,
    input  aisp_pkg::queue_stat_t q_stat,
    output logic                push,
    output aisp_pkg::payload_t  push_data
);

    logic [aisp_pkg::LINE_POS_W-1:0] line_pos_reg, line_pos_next;
    logic                            prefix_ok_reg, prefix_ok_next;
    logic [aisp_pkg::FIELD_W-1:0]    field_reg, field_next;
    logic [aisp_pkg::SYM_CNT_W-1:0]  sym_cnt_reg, sym_cnt_next;
    aisp_pkg::payload_t              payload_reg, payload_next;

    logic                                accept;
    logic                                eol;
    logic                                report_ok;
    logic [aisp_pkg::SYMBOL_BITS-1:0]    symbol;

    // Stall only on a full queue
    assign char_stall = q_stat.full;
    assign accept     = char_valid && !char_stall;
    assign eol        = (char_byte == aisp_pkg::CHAR_LF) || (char_byte == aisp_pkg::CHAR_CR);
    assign symbol     = aisp_pkg::dearmor(char_byte);

    // Good line: full prefix and first symbol marks a position report
    assign report_ok = prefix_ok_reg
        && (line_pos_reg == aisp_pkg::LINE_POS_W'(aisp_pkg::PREFIX_LEN))
        && (payload_reg[aisp_pkg::PAYLOAD_BITS-1 -: aisp_pkg::SYMBOL_BITS]
            == aisp_pkg::SYMBOL_BITS'(aisp_pkg::MSG_TYPE_POS));

    assign push      = accept && eol && report_ok;
    assign push_data = payload_reg;

    // Line state update
    always_comb
    begin
        line_pos_next  = line_pos_reg;
        prefix_ok_next = prefix_ok_reg;
        field_next     = field_reg;
        sym_cnt_next   = sym_cnt_reg;
        payload_next   = payload_reg;
        if (accept) begin
            if (eol) begin
                line_pos_next  = '0;
                prefix_ok_next = 1'b1;
                field_next     = '0;
                sym_cnt_next   = '0;
                payload_next   = '0;
            end
            else begin
                if (line_pos_reg < aisp_pkg::LINE_POS_W'(aisp_pkg::PREFIX_LEN)) begin
                    if (char_byte != aisp_pkg::prefix_char(line_pos_reg))
                        prefix_ok_next = 1'b0;
                    line_pos_next = line_pos_reg + 1'b1;
                end
                if ((char_byte == aisp_pkg::CHAR_COMMA) || (char_byte == aisp_pkg::CHAR_STAR)) begin
                    if (field_reg != '1)
                        field_next = field_reg + 1'b1;
                end
                else if ((field_reg == aisp_pkg::FIELD_W'(aisp_pkg::PAYLOAD_FIELD))
                         && (sym_cnt_reg < aisp_pkg::SYM_CNT_W'(aisp_pkg::MAX_SYMBOLS))) begin
                    for (int k = 0; k < aisp_pkg::MAX_SYMBOLS; k++) begin
                        if (sym_cnt_reg == aisp_pkg::SYM_CNT_W'(k))
                            payload_next[aisp_pkg::PAYLOAD_BITS-1-aisp_pkg::SYMBOL_BITS*k
                                         -: aisp_pkg::SYMBOL_BITS] = symbol;
                    end
                    sym_cnt_next = sym_cnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_pos_reg  <= '0;
            prefix_ok_reg <= 1'b1;
            field_reg     <= '0;
            sym_cnt_reg   <= '0;
            payload_reg   <= '0;
        end
        else begin
            line_pos_reg  <= line_pos_next;
            prefix_ok_reg <= prefix_ok_next;
            field_reg     <= field_next;
            sym_cnt_reg   <= sym_cnt_next;
            payload_reg   <= payload_next;
        end
    end

    `AISP_ASSERT_IMP(a_sym_cnt_bound, clk, rst_n, 1'b1,
        sym_cnt_reg <= aisp_pkg::SYM_CNT_W'(aisp_pkg::MAX_SYMBOLS))
    `AISP_ASSERT_NXT(a_line_cleared, clk, rst_n, accept && eol,
        (sym_cnt_reg == '0) && (field_reg == '0) && (line_pos_reg == '0) && prefix_ok_reg)

endmodule

>>> sv/aisp_queue.sv
// Short payload queue between the line parser and the report decoder.
`include "ais_position_report_decoder_top_macros.svh"

module aisp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  aisp_pkg::payload_t    push_data,
    input  logic                  pop,
    output aisp_pkg::payload_t    pop_data,
    output aisp_pkg::queue_stat_t q_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    aisp_pkg::payload_t entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_W'(DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    `AISP_ASSERT_IMP(a_no_push_full, clk, rst_n, q_stat.full, !push)
    `AISP_ASSERT_IMP(a_no_pop_empty, clk, rst_n, q_stat.empty, !pop)
    `AISP_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

>>> sv/aisp_back.sv
// Report decoder: field extraction, turn squaring and output register.
module aisp_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  aisp_pkg::payload_t    pop_data,
    input  aisp_pkg::queue_stat_t q_stat,
    output logic                  pop,
    output logic                  report_valid,
    input  logic                  report_stall,
    output logic [1:0]            repeat_count,
    output logic [29:0]           mmsi,
    output logic [3:0]            nav_status,
    output logic signed [14:0]    turn_square,
    output logic [9:0]            speed_tenths,
    output logic signed [27:0]    longitude,
    output logic signed [26:0]    latitude,
    output logic [11:0]           course_tenths,
    output logic [8:0]            heading_deg,
    output logic [5:0]            utc_second,
    output logic [3:0]            flags,
    output logic [18:0]           radio_status
);

    localparam int TOP = aisp_pkg::PAYLOAD_BITS - 1;

    logic               valid_reg, valid_next;
    logic               load;
    logic signed [7:0]  turn_raw;
    logic [7:0]         turn_mag;
    logic signed [16:0] turn_prod;

    logic [1:0]         repeat_reg;
    logic [29:0]        mmsi_reg;
    logic [3:0]         status_reg;
    logic signed [14:0] turn_reg;
    logic [9:0]         speed_reg;
    logic signed [27:0] lon_reg;
    logic signed [26:0] lat_reg;
    logic [11:0]        course_reg;
    logic [8:0]         heading_reg;
    logic [5:0]         second_reg;
    logic [3:0]         flags_reg;
    logic [18:0]        radio_reg;

    // Take a report when the output slot is free or being drained
    assign load = !q_stat.empty && (!valid_reg || !report_stall);
    assign pop  = load;

    // Rate of turn times its magnitude
    assign turn_raw  = $signed(pop_data[TOP-aisp_pkg::POS_TURN -: 8]);
    assign turn_mag  = turn_raw[7] ? 8'(-turn_raw) : 8'(turn_raw);
    assign turn_prod = turn_raw * $signed({1'b0, turn_mag});

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (!report_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load) begin
            repeat_reg  <= pop_data[TOP-aisp_pkg::POS_REPEAT -: 2];
            mmsi_reg    <= pop_data[TOP-aisp_pkg::POS_MMSI -: 30];
            status_reg  <= pop_data[TOP-aisp_pkg::POS_STATUS -: 4];
            turn_reg    <= turn_prod[14:0];
            speed_reg   <= pop_data[TOP-aisp_pkg::POS_SPEED -: 10];
            lon_reg     <= $signed(pop_data[TOP-aisp_pkg::POS_LON -: 28]);
            lat_reg     <= $signed(pop_data[TOP-aisp_pkg::POS_LAT -: 27]);
            course_reg  <= pop_data[TOP-aisp_pkg::POS_COURSE -: 12];
            heading_reg <= pop_data[TOP-aisp_pkg::POS_HEADING -: 9];
            second_reg  <= pop_data[TOP-aisp_pkg::POS_SECOND -: 6];
            flags_reg   <= {pop_data[TOP-aisp_pkg::POS_MANEUVER -: 2],
                            pop_data[TOP-aisp_pkg::POS_RAIM],
                            pop_data[TOP-aisp_pkg::POS_ACCURACY]};
            radio_reg   <= pop_data[TOP-aisp_pkg::POS_RADIO -: 19];
        end
    end

    assign report_valid  = valid_reg;
    assign repeat_count  = repeat_reg;
    assign mmsi          = mmsi_reg;
    assign nav_status    = status_reg;
    assign turn_square   = turn_reg;
    assign speed_tenths  = speed_reg;
    assign longitude     = lon_reg;
    assign latitude      = lat_reg;
    assign course_tenths = course_reg;
    assign heading_deg   = heading_reg;
    assign utc_second    = second_reg;
    assign flags         = flags_reg;
    assign radio_status  = radio_reg;

endmodule

>>> sv/ais_position_report_decoder_top.sv
// Top level of the AIS position report decoder: parser, queue and report decoder.
//
//   channel   direction  handshake                  payload
//   char      in         char_valid / char_stall    char_byte
//   report    out        report_valid / report_stall repeat_count .. radio_status
//
// One character is taken per cycle while the payload queue has room.
// A report passes through the payload queue and then the output register
// once its line-end character is accepted.
// char_stall rises only when QUEUE_DEPTH finished reports wait behind a
// stalled output; report_stall never holds back characters until then.
// Reset clears the line state, the queue and the output valid; no clearing pass.
module ais_position_report_decoder_top
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         char_byte,
    output logic               report_valid,
    input  logic               report_stall,
    output logic [1:0]         repeat_count,
    output logic [29:0]        mmsi,
    output logic [3:0]         nav_status,
    output logic signed [14:0] turn_square,
    output logic [9:0]         speed_tenths,
    output logic signed [27:0] longitude,
    output logic signed [26:0] latitude,
    output logic [11:0]        course_tenths,
    output logic [8:0]         heading_deg,
    output logic [5:0]         utc_second,
    output logic [3:0]         flags,
    output logic [18:0]        radio_status
);

    aisp_pkg::queue_stat_t q_stat;
    aisp_pkg::payload_t    push_data;
    aisp_pkg::payload_t    pop_data;
    logic                  push;
    logic                  pop;

    aisp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .char_byte  (char_byte),
        .q_stat     (q_stat),
        .push       (push),
        .push_data  (push_data)
    );

    aisp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    aisp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_data      (pop_data),
        .q_stat        (q_stat),
        .pop           (pop),
        .report_valid  (report_valid),
        .report_stall  (report_stall),
        .repeat_count  (repeat_count),
        .mmsi          (mmsi),
        .nav_status    (nav_status),
        .turn_square   (turn_square),
        .speed_tenths  (speed_tenths),
        .longitude     (longitude),
        .latitude      (latitude),
        .course_tenths (course_tenths),
        .heading_deg   (heading_deg),
        .utc_second    (utc_second),
        .flags         (flags),
        .radio_status  (radio_status)
    );

endmodule
